// ----- hdl/sto_pkg.sv -----
// ----------------------------------------------------------------------------
// sto_pkg: shared definitions for the sine tone oscillator
// Register indexes, default parameters and the quarter-wave sine generator
// used to fill the sine table at elaboration.
// ----------------------------------------------------------------------------
package sto_pkg;

   localparam int TABLE_INDEX_BITS_DEF = 10;
   localparam int MAX_CHANNELS_DEF     = 8;

   localparam int PHASE_W   = 32;
   localparam int SAMPLE_W  = 16;
   localparam int CHANNEL_W = 3;
   localparam int VOLUME_W  = 16;
   localparam int COUNT_W   = 4;
   localparam int SINE_W    = 15;
   localparam int CSR_ADDR_W = 1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_VOLUME        = 1'b0,
      REG_CHANNEL_COUNT = 1'b1
   } csr_reg_type;

   localparam logic [VOLUME_W-1:0] VOLUME_RESET = 16'd32768;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 4'd2;

   localparam longint unsigned POLY_A = 64'd102944;
   localparam longint unsigned POLY_B = 64'd42334;
   localparam longint unsigned POLY_C = 64'd5223;

   // First-quadrant sine in Q0.15 for position pos, 0 to 2^(index_bits-2) inclusive.
   function automatic logic [SINE_W-1:0] quarter_sine(input int pos, input int index_bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned y;
      longint unsigned s;
      x  = longint'(pos) << (16 - (index_bits - 2));
      x2 = (x * x) >> 16;
      t  = POLY_B - ((x2 * POLY_C) >> 16);
      t  = POLY_A - ((x2 * t) >> 16);
      y  = (x * t) >> 16;
      if (y > 64'd65536) begin
         y = 64'd65536;
      end
      s = (y * 64'd32767 + 64'd32768) >> 16;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return s[SINE_W-1:0];
   endfunction

endpackage

// ----- hdl/sine_tone_oscillator.sv -----
// ----------------------------------------------------------------------------
// sine_tone_oscillator: direct digital synthesis sine source
// A 32-bit phase accumulator advances by each frame's phase step; the sine
// of the phase before the step, scaled by volume, is sent once per channel.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  req_      in         tvalid / tready      tdata = phase_step
//  rsp_      out        tvalid / tready      tdata = sample, tuser = channel,
//                                            tlast = last channel of frame
//  csr_      in         we (no wait)         addr, wdata
//
//  The first sample of a frame is registered in turn by phase decode into the
//  input stage at the take, by the sine table read, and by the volume
//  multiply into the output register.
//  A frame holds the output register until its last channel is taken; the next
//  frame waits in the two internal stages, so a new frame can be taken while
//  one is being sent (channel count clamped to 1..MAX_CHANNELS).
//  Reset is synchronous: phase clears to zero, volume 32768, two channels.
//  A stalled output holds its item; upstream stages fill and then drop ready.
module sine_tone_oscillator #(
   parameter int TABLE_INDEX_BITS = sto_pkg::TABLE_INDEX_BITS_DEF,
   parameter int MAX_CHANNELS     = sto_pkg::MAX_CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sto_pkg::PHASE_W-1:0]     req_tdata,   // [31:0] phase_step
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sto_pkg::SAMPLE_W-1:0]    rsp_tdata,   // [15:0] sample
   output logic [sto_pkg::CHANNEL_W-1:0]   rsp_tuser,   // [2:0] channel
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [sto_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [sto_pkg::VOLUME_W-1:0]    csr_wdata
);
   import sto_pkg::*;

   localparam int POS_W = TABLE_INDEX_BITS - 1;
   localparam int K_W   = TABLE_INDEX_BITS - 2;
   localparam int QUARTER = 1 << K_W;
   localparam logic [POS_W-1:0] QUARTER_POS = POS_W'(QUARTER);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_CHANNELS);

   // sine table, quarter wave plus the end point
   logic [SINE_W-1:0] sine_rom [QUARTER+1];
   for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
      assign sine_rom[g] = quarter_sine(g, TABLE_INDEX_BITS);
   end

   // configuration
   logic [VOLUME_W-1:0] volume_ff;
   logic [COUNT_W-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= VOLUME_RESET;
         count_ff  <= COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_addr))
            REG_VOLUME:        volume_ff <= csr_wdata;
            REG_CHANNEL_COUNT: count_ff  <= csr_wdata[COUNT_W-1:0];
            default:           ;
         endcase
      end
   end

   // pipeline registers
   logic [PHASE_W-1:0]   phase_ff;
   logic                 a_valid_ff;
   logic [POS_W-1:0]     a_pos_ff;
   logic                 a_neg_ff;
   logic                 b_valid_ff;
   logic [SINE_W-1:0]    b_sine_ff;
   logic                 b_neg_ff;
   logic                 out_valid_ff;
   logic [SAMPLE_W-1:0]  out_sample_ff;
   logic [CHANNEL_W-1:0] out_chan_ff;
   logic [CHANNEL_W-1:0] out_last_chan_ff;
   logic                 out_last_ff;

   logic                 req_take;
   logic                 rsp_take;
   logic                 out_load;
   logic                 a_move;
   logic [TABLE_INDEX_BITS-1:0] idx;
   logic [K_W-1:0]       k;
   logic [POS_W-1:0]     pos_in;
   logic [31:0]          prod;
   logic [SINE_W-1:0]    mag;
   logic [SAMPLE_W-1:0]  sample_in;
   logic [COUNT_W-1:0]   count_eff;
   logic [CHANNEL_W-1:0] last_chan_in;
   logic [CHANNEL_W-1:0] chan_in;

   assign rsp_take = out_valid_ff && rsp_tready;
   assign out_load = b_valid_ff && (!out_valid_ff || (rsp_take && out_last_ff));
   assign a_move   = a_valid_ff && (!b_valid_ff || out_load);
   assign req_tready = !a_valid_ff || !b_valid_ff || out_load;
   assign req_take = req_tvalid && req_tready;

   // decode quadrant and position from the phase before this frame's step
   always_comb begin
      idx = phase_ff[PHASE_W-1 -: TABLE_INDEX_BITS];
      k   = idx[K_W-1:0];
      if (idx[K_W]) begin
         pos_in = QUARTER_POS - {1'b0, k};
      end else begin
         pos_in = {1'b0, k};
      end
   end

   // volume scaling with rounding, sign applied after
   always_comb begin
      prod = 32'(b_sine_ff) * 32'(volume_ff) + 32'd32768;
      mag  = prod[16 +: SINE_W];
      if (b_neg_ff) begin
         sample_in = SAMPLE_W'(0) - {1'b0, mag};
      end else begin
         sample_in = {1'b0, mag};
      end
   end

   always_comb begin
      priority if (count_ff == '0) begin
         count_eff = COUNT_W'(1);
      end else if (count_ff > MAX_COUNT) begin
         count_eff = MAX_COUNT;
      end else begin
         count_eff = count_ff;
      end
      last_chan_in = CHANNEL_W'(count_eff - COUNT_W'(1));
      chan_in = out_chan_ff + CHANNEL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            phase_ff <= phase_ff + req_tdata;
         end
         if (req_take) begin
            a_valid_ff <= 1'b1;
         end else if (a_move) begin
            a_valid_ff <= 1'b0;
         end
         if (a_move) begin
            b_valid_ff <= 1'b1;
         end else if (out_load) begin
            b_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_take && out_last_ff) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_pos_ff <= pos_in;
         a_neg_ff <= idx[K_W+1];
      end
      if (a_move) begin
         b_sine_ff <= sine_rom[a_pos_ff];
         b_neg_ff  <= a_neg_ff;
      end
      if (out_load) begin
         out_sample_ff    <= sample_in;
         out_chan_ff      <= '0;
         out_last_chan_ff <= last_chan_in;
         out_last_ff      <= (last_chan_in == '0);
      end else if (rsp_take && !out_last_ff) begin
         // advance to the next channel of the same frame
         out_chan_ff <= chan_in;
         out_last_ff <= (chan_in == out_last_chan_ff);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sample_ff;
   assign rsp_tuser  = out_chan_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- hdl/sto_checker.sv -----
// ----------------------------------------------------------------------------
// sto_checker: port-level checks for the sine tone oscillator
// Watches the result channel for frame ordering and sample consistency.
// ----------------------------------------------------------------------------
module sto_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sto_pkg::SAMPLE_W-1:0]    rsp_tdata,
   input logic [sto_pkg::CHANNEL_W-1:0]   rsp_tuser,
   input logic                            rsp_tlast
);
   import sto_pkg::*;

   logic rsp_take;
   assign rsp_take = rsp_tvalid && rsp_tready;

   // within a frame the next channel follows straight away
   a_next_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_tlast |=> rsp_tvalid && (rsp_tuser == $past(rsp_tuser) + 3'd1))
      else $error("channel did not advance within frame");

   // every channel of a frame carries the same sample
   a_same_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_tlast |=> rsp_tdata == $past(rsp_tdata))
      else $error("sample changed within frame");

   // a new frame starts at channel zero
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_tlast |=> !rsp_tvalid || (rsp_tuser == '0))
      else $error("frame did not start at channel zero");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled item not held");

endmodule

bind sine_tone_oscillator sto_checker u_sto_checker (.*);

// ----- test/sine_tone_oscillator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_tone_oscillator_tb: self-checking bench for the tone oscillator
// Streams phase steps into the block and checks every channel sample against
// a cycle-free model of the phase accumulator, the quarter-wave sine and the
// volume scaling. Volume and channel count are rewritten between phases while
// the block is drained; both stream sides idle at random, and one phase holds
// the sample side off long enough to back the block up.
// ----------------------------------------------------------------------------
module sine_tone_oscillator_tb;

   import sto_pkg::*;

   localparam int IDX_BITS    = TABLE_INDEX_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 16;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  sample;
      logic [CHANNEL_W-1:0] channel;
      logic                 last;
   } tone_sample_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PHASE_W-1:0]    req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_tdata;
   logic [CHANNEL_W-1:0]  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = REG_VOLUME;
   logic [VOLUME_W-1:0]   csr_wdata = '0;

   // mirror of the block's state and registers
   logic [PHASE_W-1:0]  phase_acc = '0;
   logic [VOLUME_W-1:0] volume_setting = VOLUME_RESET;
   logic [COUNT_W-1:0]  count_setting = COUNT_RESET;

   tone_sample_type pending_samples[$];
   tone_sample_type head_item;
   int  errors = 0;
   int  cycles = 0;
   int  hold_request = 0;
   int  rsp_burst = 0;
   bit  send_idle = 1'b1;
   bit  rsp_idle = 1'b1;

   sine_tone_oscillator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // First-quadrant level for position pos, polynomial in Q16.
   function automatic longint unsigned quadrant_level(input longint unsigned pos);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned y;
      longint unsigned s;
      x  = pos << (16 - (IDX_BITS - 2));
      x2 = (x * x) >> 16;
      t  = POLY_B - ((x2 * POLY_C) >> 16);
      t  = POLY_A - ((x2 * t) >> 16);
      y  = (x * t) >> 16;
      if (y > 64'd65536) begin
         y = 64'd65536;
      end
      s = (y * 64'd32767 + 64'd32768) >> 16;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return s;
   endfunction

   function automatic logic [SAMPLE_W-1:0] tone_level(input logic [PHASE_W-1:0] phase);
      logic [IDX_BITS-1:0] idx;
      logic [1:0]          quad;
      longint unsigned     quarter;
      longint unsigned     k;
      longint unsigned     pos;
      longint unsigned     mag;
      idx     = phase[PHASE_W-1 -: IDX_BITS];
      quad    = idx[IDX_BITS-1 -: 2];
      quarter = 64'd1 << (IDX_BITS - 2);
      k       = longint'(idx) & (quarter - 1);
      pos     = quad[0] ? quarter - k : k;
      mag     = (quadrant_level(pos) * volume_setting + 64'd32768) >> 16;
      // lower half of the circle: negate the magnitude
      if (quad[1]) begin
         return SAMPLE_W'(-mag);
      end
      return SAMPLE_W'(mag);
   endfunction

   function automatic void predict_frame(input logic [PHASE_W-1:0] step);
      int              n;
      tone_sample_type item;
      n = int'(count_setting);
      if (n == 0) begin
         n = 1;
      end
      if (n > MAX_CHANNELS_DEF) begin
         n = MAX_CHANNELS_DEF;
      end
      item.sample = tone_level(phase_acc);
      for (int ch = 0; ch < n; ch++) begin
         item.channel = CHANNEL_W'(ch);
         item.last    = (ch == n - 1);
         pending_samples.push_back(item);
      end
      phase_acc = phase_acc + step;
   endfunction

   // Offer one item; valid stays high after acceptance until the next call.
   task automatic send_frame(input logic [PHASE_W-1:0] step);
      int gap;
      if (send_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= step;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_frame(step);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_register(input csr_reg_type idx, input logic [VOLUME_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_VOLUME) begin
         volume_setting = value;
      end else begin
         count_setting = value[COUNT_W-1:0];
      end
      @(posedge clock);
   endtask

   function automatic logic [PHASE_W-1:0] pick_step();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h00FF_FFFF);
         2: return {2'($urandom_range(0, 3)), 30'h0} + $urandom_range(0, 32'h0000_FFFF);
         default: begin
            case ($urandom_range(0, 2))
               0: return '0;
               1: return '1;
               default: return 32'h1 << $urandom_range(0, 31);
            endcase
         end
      endcase
   endfunction

   // Defaults after reset: zero step, quarter turns, wrap of the accumulator.
   task automatic test_reset_defaults();
      send_frame(32'h0000_0000);
      repeat (4) send_frame(32'h4000_0000);
      send_frame(32'h003F_FFFF);
      send_frame(32'hFFFF_FFFF);
      wait_drained();
   endtask

   task automatic test_volume_extremes();
      write_register(REG_VOLUME, 16'hFFFF);
      repeat (4) send_frame(32'h4000_0000);
      wait_drained();
      write_register(REG_VOLUME, 16'h0000);
      send_frame(32'h4000_0000);
      send_frame(32'hC000_0000);
      wait_drained();
   endtask

   // Zero channels acts as one; above the maximum saturates.
   task automatic test_channel_counts();
      logic [VOLUME_W-1:0] counts[5];
      counts = '{16'd0, 16'd1, 16'd8, 16'd9, 16'hFFFF};
      write_register(REG_VOLUME, 16'd40000);
      foreach (counts[i]) begin
         write_register(REG_CHANNEL_COUNT, counts[i]);
         send_frame(32'h1234_5678);
         send_frame(32'h9ABC_DEF0);
         wait_drained();
      end
   endtask

   task automatic run_random_round(input int round, input int items);
      logic [VOLUME_W-1:0] vol;
      case (round % 4)
         0: vol = 16'h0000;
         1: vol = 16'hFFFF;
         default: vol = VOLUME_W'($urandom);
      endcase
      write_register(REG_VOLUME, vol);
      write_register(REG_CHANNEL_COUNT, VOLUME_W'($urandom));
      repeat (items) send_frame(pick_step());
      wait_drained();
   endtask

   task automatic test_random_settings();
      for (int r = 0; r < 8; r++) begin
         run_random_round(r, 20);
      end
   endtask

   // Hold the sample side off while frames keep coming, so ready drops.
   task automatic test_backpressure();
      write_register(REG_CHANNEL_COUNT, 16'd8);
      send_idle    = 1'b0;
      hold_request = 400;
      repeat (20) send_frame(pick_step());
      wait_drained();
      send_idle = 1'b1;
   endtask

   task automatic test_streaming_no_idle();
      send_idle = 1'b0;
      rsp_idle  = 1'b0;
      run_random_round(2, 12);
      run_random_round(3, 12);
   endtask

   // sample side: long hold first, then random stall bursts
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_request <= hold_request - 1;
         rsp_tready   <= 1'b0;
      end else if (rsp_burst > 0) begin
         rsp_burst  <= rsp_burst - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_idle && $urandom_range(0, 7) == 0) begin
         rsp_burst  <= $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            errors++;
            $display("%0t: unexpected item: expected none, actual sample %h channel %0d last %0b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            head_item = pending_samples.pop_front();
            if (rsp_tdata !== head_item.sample || rsp_tuser !== head_item.channel ||
                rsp_tlast !== head_item.last) begin
               errors++;
               $display("%0t: mismatch: expected %h/%0d/%0b actual %h/%0d/%0b",
                        $time, head_item.sample, head_item.channel, head_item.last,
                        rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("sine_tone_oscillator_tb: FAIL");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_volume_extremes();
      test_channel_counts();
      test_random_settings();
      test_backpressure();
      test_streaming_no_idle();
      wait_drained();
      if (errors == 0) begin
         $display("sine_tone_oscillator_tb: PASS");
      end else begin
         $display("sine_tone_oscillator_tb: FAIL");
      end
      $finish;
   end

endmodule
